### src/tksi_pkg.sv
// Shared constants, command struct and key ordering function for the sorted insert unit.
package tksi_pkg;

    localparam int DEF_CAPACITY      = 16;
    localparam int TIME_W            = 32;
    localparam int FAULT_W           = 16;
    localparam int ID_W              = 32;
    localparam int MAX_ENTRIES_W     = 5;
    localparam int RANK_W            = 5;
    localparam int FILL_W            = 5;
    localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RST = 5'd16;

    typedef struct packed {
        logic cfg_write;   // take new max_entries value
        logic load_in;     // capture the incoming request
        logic compare;     // register per-entry comparisons
        logic update;      // shift the table and load the result register
    } t_dp_cmd;

    // true when record a orders strictly before record b
    function automatic logic goes_before(
        input logic [TIME_W-1:0]  ta,
        input logic [FAULT_W-1:0] fa,
        input logic [ID_W-1:0]    ia,
        input logic [TIME_W-1:0]  tb,
        input logic [FAULT_W-1:0] fb,
        input logic [ID_W-1:0]    ib
    );
        logic res;
        if (ta != tb) begin
            res = (ta < tb);
        end else if (fa != fb) begin
            res = (fa < fb);
        end else begin
            res = (ia < ib);
        end
        return res;
    endfunction

endpackage

### src/tksi_ctrl.sv
// Controller state machine sequencing accept, compare and update for the sorted insert unit.
module tksi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output tksi_pkg::t_dp_cmd o_cmd
);
    import tksi_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd         = '0;
        o_cmd.cfg_write = i_cfg_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/tksi_dp.sv
// Datapath of the sorted insert unit: table cells, comparators, shift and result register.
module tksi_dp #(
    parameter int CAPACITY = tksi_pkg::DEF_CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tksi_pkg::t_dp_cmd                    i_cmd,
    input  logic [tksi_pkg::MAX_ENTRIES_W-1:0]   i_cfg_max_entries,
    input  logic [tksi_pkg::TIME_W-1:0]          i_time_ms,
    input  logic [tksi_pkg::FAULT_W-1:0]         i_fault_count,
    input  logic [tksi_pkg::ID_W-1:0]            i_record_id,
    output logic [tksi_pkg::RANK_W-1:0]          o_rank,
    output logic                                 o_kept,
    output logic [tksi_pkg::FILL_W-1:0]          o_fill_count
);
    import tksi_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > MAX_ENTRIES_W) ? CW : MAX_ENTRIES_W;
    localparam int NW = MW + 1;

    logic [MAX_ENTRIES_W-1:0] r_max_entries;
    logic [CW-1:0]            r_count;

    logic [TIME_W-1:0]        r_time;
    logic [FAULT_W-1:0]       r_fault;
    logic [ID_W-1:0]          r_id;

    logic [TIME_W-1:0]        r_cell_time  [CAPACITY];
    logic [FAULT_W-1:0]       r_cell_fault [CAPACITY];
    logic [ID_W-1:0]          r_cell_id    [CAPACITY];

    logic [CAPACITY-1:0]      n_le;
    logic [CAPACITY-1:0]      r_le;
    logic [CW-1:0]            r_newcount;
    logic [CW-1:0]            n_newcount;

    logic [CAPACITY-1:0]      hot;
    logic [CW-1:0]            pos;
    logic                     kept;
    logic [NW-1:0]            rank_ext;
    logic [NW-1:0]            fill_ext;

    logic [RANK_W-1:0]        r_rank;
    logic                     r_kept;
    logic [FILL_W-1:0]        r_fill;

    // configuration and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
            r_count       <= '0;
        end else begin
            if (i_cmd.cfg_write) begin
                r_max_entries <= i_cfg_max_entries;
            end
            if (i_cmd.update) begin
                r_count <= r_newcount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_time  <= i_time_ms;
            r_fault <= i_fault_count;
            r_id    <= i_record_id;
        end
    end

    // new count: one more entry, clipped to the effective limit
    always_comb begin
        logic [NW-1:0] n_plus;
        logic [NW-1:0] limit;
        n_plus = {{(NW-CW){1'b0}}, r_count} + NW'(1);
        limit  = {{(NW-MAX_ENTRIES_W){1'b0}}, r_max_entries};
        if (limit > NW'(CAPACITY)) begin
            limit = NW'(CAPACITY);
        end
        if (n_plus > limit) begin
            n_newcount = limit[CW-1:0];
        end else begin
            n_newcount = n_plus[CW-1:0];
        end
    end

    // per-cell comparison: entry is valid and does not order after the request
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cmp
        assign n_le[gi] = (CW'(gi) < r_count) &&
                          !goes_before(r_time, r_fault, r_id,
                                       r_cell_time[gi], r_cell_fault[gi], r_cell_id[gi]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_le       <= n_le;
            r_newcount <= n_newcount;
        end
    end

    // the comparison vector is a run of ones; the insert slot is its first zero
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_hot
        if (gi == 0) begin : g_first
            assign hot[gi] = !r_le[gi];
        end else begin : g_rest
            assign hot[gi] = r_le[gi-1] && !r_le[gi];
        end
    end

    always_comb begin
        pos = r_le[CAPACITY-1] ? CW'(CAPACITY) : '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (hot[k]) begin
                pos = pos | CW'(k);
            end
        end
    end

    assign kept     = (pos < r_newcount);
    assign rank_ext = {{(NW-CW){1'b0}}, pos} + NW'(1);
    assign fill_ext = {{(NW-CW){1'b0}}, r_newcount};

    // table cells: write the request at its slot, shift the tail down one place
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.update && (CW'(gi) < r_newcount)) begin
                if (hot[gi]) begin
                    r_cell_time[gi]  <= r_time;
                    r_cell_fault[gi] <= r_fault;
                    r_cell_id[gi]    <= r_id;
                end else if ((gi > 0) && !r_le[(gi > 0) ? gi-1 : 0]) begin
                    r_cell_time[gi]  <= r_cell_time[(gi > 0) ? gi-1 : 0];
                    r_cell_fault[gi] <= r_cell_fault[(gi > 0) ? gi-1 : 0];
                    r_cell_id[gi]    <= r_cell_id[(gi > 0) ? gi-1 : 0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rank <= kept ? rank_ext[RANK_W-1:0] : '0;
            r_kept <= kept;
            r_fill <= fill_ext[FILL_W-1:0];
        end
    end

    assign o_rank       = r_rank;
    assign o_kept       = r_kept;
    assign o_fill_count = r_fill;

endmodule

### src/top_k_sorted_insert_unit.sv
// Top level of the sorted insert unit: bounded leaderboard table kept in ascending key order.
//
// Usage: each request on the input channel (i_in_valid / o_in_stall) carries time_ms,
// fault_count and record_id. The record is inserted in order (time, then faults, then
// id, smaller first; equal keys go after the existing entry) and the table is cut to
// max_entries (clipped to CAPACITY). One result per request appears on the output
// channel (o_out_valid / i_out_stall): 1-based rank or 0, the kept flag and the fill
// count after the insert.
// Steps per request: accept, compare all cells in parallel, then shift the table and
// load the result register. A new request is taken only once the update step is
// done.
// The result register parts the two sides: a request may be accepted while the
// previous result still waits; the update step holds while i_out_stall keeps the
// result register full, and o_in_stall stays high meanwhile.
// max_entries is written over the cfg channel (always ready); write it only when idle.
// Reset (synchronous, active low) empties the table and sets max_entries to 16; no
// clearing pass is needed.
module top_k_sorted_insert_unit #(
    parameter int CAPACITY = tksi_pkg::DEF_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [tksi_pkg::TIME_W-1:0]        i_time_ms,
    input  logic [tksi_pkg::FAULT_W-1:0]       i_fault_count,
    input  logic [tksi_pkg::ID_W-1:0]          i_record_id,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [tksi_pkg::RANK_W-1:0]        o_rank,
    output logic                               o_kept,
    output logic [tksi_pkg::FILL_W-1:0]        o_fill_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tksi_pkg::MAX_ENTRIES_W-1:0] i_cfg_max_entries
);
    import tksi_pkg::*;

    t_dp_cmd cmd;

    tksi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    tksi_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_max_entries (i_cfg_max_entries),
        .i_time_ms         (i_time_ms),
        .i_fault_count     (i_fault_count),
        .i_record_id       (i_record_id),
        .o_rank            (o_rank),
        .o_kept            (o_kept),
        .o_fill_count      (o_fill_count)
    );

endmodule
